[design/circle_region_trait_tally_unit_defines.svh]
// Assertion macros used by the checker file of this block.
`ifndef CIRCLE_REGION_TRAIT_TALLY_UNIT_DEFINES_SVH
`define CIRCLE_REGION_TRAIT_TALLY_UNIT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define CRTT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("crtt check failed");

// A condition in one cycle that must be followed by another in the next cycle.
`define CRTT_ASSERT_NEXT(lbl, clk, rstn, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) \
    else $error("crtt check failed");

`endif

[design/crtt_pkg.sv]
package crtt_pkg;

  localparam int unsigned MaxRegions = 16;
  localparam int unsigned RegionIdxW = 4;
  localparam int unsigned MaxTraits  = 8;
  localparam int unsigned TraitIdxW  = 3;
  localparam int unsigned MaxSpecies = 8;
  localparam int unsigned SpeciesW   = 3;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned RadiusW    = 16;
  localparam int unsigned MaskW      = 8;
  localparam int unsigned WidenW     = 10;
  localparam int unsigned MulW       = 26;
  localparam int unsigned ProdW      = 2 * MulW;
  localparam int unsigned DistW      = 34;
  localparam int unsigned CountOutW  = 10;
  localparam int unsigned CfgW       = 10;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [2:0] OpLoadRegion = 3'd0;
  localparam logic [2:0] OpLoadMask   = 3'd1;
  localparam logic [2:0] OpClear      = 3'd2;
  localparam logic [2:0] OpPosition   = 3'd3;
  localparam logic [2:0] OpRead       = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgRegions = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTraits  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWiden   = 2'd2;

  localparam logic [4:0]        RegionsReset = 5'd1;
  localparam logic [3:0]        TraitsReset  = 4'd8;
  localparam logic [WidenW-1:0] WidenReset   = 10'd307;

  typedef struct packed {
    logic [CoordW-1:0]  cx;
    logic [CoordW-1:0]  cy;
    logic [RadiusW-1:0] radius;
  } region_t;

endpackage

[design/circle_region_trait_tally_unit.sv]
// Loads, clears and unknown items: result strobe in the cycle after start, busy stays low.
// Counter read: the count RAM row is read, then registered out in StRead, while busy.
// Position: each region examined passes StSqX, StSqY, StWr, StWSq and StCmp on the
// single shared 26x26 multiplier; a hit adds StUpd; the strobe follows the last state.
// Reset loads config defaults, clears control and all counters at once; region and mask
// tables are not cleared. Results are shown for one cycle and cannot be stalled.
module circle_region_trait_tally_unit
  import crtt_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               op_i,
  input  logic [RegionIdxW-1:0]    entry_i,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic [RadiusW-1:0]       region_radius_i,
  input  logic [MaskW-1:0]         trait_mask_i,
  input  logic [SpeciesW-1:0]      species_id_i,
  input  logic [TraitIdxW-1:0]     trait_select_i,
  output logic                     result_valid_o,
  output logic                     hit_o,
  output logic [RegionIdxW-1:0]    region_found_o,
  output logic [CountOutW-1:0]     count_value_o
);

  localparam int unsigned RowW = MaxTraits * COUNT_BITS;
  localparam int unsigned RegW = $bits(region_t);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StSqX  = 3'd2;
  localparam logic [2:0] StSqY  = 3'd3;
  localparam logic [2:0] StWr   = 3'd4;
  localparam logic [2:0] StWSq  = 3'd5;
  localparam logic [2:0] StCmp  = 3'd6;
  localparam logic [2:0] StUpd  = 3'd7;

  logic [2:0]             state_q, state_d;
  logic [RegionIdxW-1:0]  idx_q, idx_d;
  logic [CoordW-1:0]      px_q, py_q;
  logic [SpeciesW-1:0]    species_q;
  logic [RegionIdxW-1:0]  entry_q;
  logic [TraitIdxW-1:0]   tsel_q;
  logic [ProdW-1:0]       prod_q, prod_d;
  logic [DistW-1:0]       d2_q, d2_d;
  logic                   prod_en;

  logic [4:0]             regions_q;
  logic [3:0]             traits_q;
  logic [WidenW-1:0]      widen_q;
  logic [MaskW-1:0]       masks_q [MaxSpecies];
  logic [MaxRegions-1:0]  row_valid_q;

  logic                   done_q, done_d;
  logic                   hit_q, hit_d;
  logic [RegionIdxW-1:0]  found_q, found_d;
  logic [CountOutW-1:0]   count_q, count_d;

  logic                   accept;
  logic                   mask_we;
  logic                   clear_all;
  logic                   row_set;
  logic [4:0]             nreg;
  logic [3:0]             ntr;
  logic                   last_region;
  logic                   in_circle;

  logic [RegionIdxW-1:0]  reg_addr;
  logic                   reg_we, reg_re;
  region_t                reg_wdata, reg_rdata;
  logic [RegW-1:0]        reg_rdata_raw;

  logic [RegionIdxW-1:0]  cnt_addr;
  logic                   cnt_we, cnt_re;
  logic [RowW-1:0]        cnt_wdata, cnt_rdata;
  logic [COUNT_BITS-1:0]  row_cnt [MaxTraits];
  logic [COUNT_BITS-1:0]  new_cnt [MaxTraits];
  logic [MaskW-1:0]       cur_mask;

  logic [CoordW:0]        dx, dy, dx_neg, dy_neg;
  logic [CoordW-1:0]      abs_dx, abs_dy;
  logic [MulW-1:0]        mul_a, mul_b;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  assign nreg = (regions_q > 5'(MaxRegions)) ? 5'(MaxRegions) : regions_q;
  assign ntr  = (traits_q > 4'(MaxTraits)) ? 4'(MaxTraits) : traits_q;
  assign last_region = ({1'b0, idx_q} == (nreg - 5'd1));

  assign reg_rdata = region_t'(reg_rdata_raw);

  // Differences are taken to 17 bits; their magnitudes always fit in 16.
  assign dx     = {px_q[CoordW-1], px_q} - {reg_rdata.cx[CoordW-1], reg_rdata.cx};
  assign dy     = {py_q[CoordW-1], py_q} - {reg_rdata.cy[CoordW-1], reg_rdata.cy};
  assign dx_neg = '0 - dx;
  assign dy_neg = '0 - dy;
  assign abs_dx = dx[CoordW] ? dx_neg[CoordW-1:0] : dx[CoordW-1:0];
  assign abs_dy = dy[CoordW] ? dy_neg[CoordW-1:0] : dy[CoordW-1:0];

  assign prod_d = mul_a * mul_b;
  assign in_circle = ({2'b00, d2_q, 16'h0000} < prod_q);

  assign cur_mask = masks_q[species_q];

  always_comb begin
    for (int j = 0; j < MaxTraits; j++) begin
      row_cnt[j] = cnt_rdata[j*COUNT_BITS +: COUNT_BITS];
    end
  end

  always_comb begin
    logic [COUNT_BITS-1:0] base;
    base = '0;
    for (int j = 0; j < MaxTraits; j++) begin
      base = row_valid_q[idx_q] ? row_cnt[j] : '0;
      if (cur_mask[j] && (4'(j) < ntr) && (base != '1)) begin
        new_cnt[j] = base + COUNT_BITS'(1);
      end else begin
        new_cnt[j] = base;
      end
      cnt_wdata[j*COUNT_BITS +: COUNT_BITS] = new_cnt[j];
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    d2_d      = d2_q;
    prod_en   = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    done_d    = 1'b0;
    hit_d     = 1'b0;
    found_d   = '0;
    count_d   = '0;
    mask_we   = 1'b0;
    clear_all = 1'b0;
    row_set   = 1'b0;
    reg_addr  = '0;
    reg_we    = 1'b0;
    reg_re    = 1'b0;
    reg_wdata = '{cx: pos_x_i, cy: pos_y_i, radius: region_radius_i};
    cnt_addr  = idx_q;
    cnt_we    = 1'b0;
    cnt_re    = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (op_i)
            OpLoadRegion: begin
              reg_we   = 1'b1;
              reg_addr = entry_i;
              done_d   = 1'b1;
            end
            OpLoadMask: begin
              mask_we = (entry_i < 4'(MaxSpecies));
              done_d  = 1'b1;
            end
            OpClear: begin
              clear_all = 1'b1;
              done_d    = 1'b1;
            end
            OpPosition: begin
              if (nreg == 5'd0) begin
                done_d = 1'b1;
              end else begin
                reg_re   = 1'b1;
                reg_addr = '0;
                idx_d    = '0;
                state_d  = StSqX;
              end
            end
            OpRead: begin
              cnt_re   = 1'b1;
              cnt_addr = entry_i;
              state_d  = StRead;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      StRead: begin
        count_d = row_valid_q[entry_q] ? CountOutW'(row_cnt[tsel_q]) : '0;
        done_d  = 1'b1;
        state_d = StIdle;
      end
      StSqX: begin
        mul_a   = MulW'(abs_dx);
        mul_b   = MulW'(abs_dx);
        prod_en = 1'b1;
        state_d = StSqY;
      end
      StSqY: begin
        mul_a   = MulW'(abs_dy);
        mul_b   = MulW'(abs_dy);
        prod_en = 1'b1;
        d2_d    = DistW'(prod_q[31:0]);
        state_d = StWr;
      end
      StWr: begin
        mul_a   = MulW'(reg_rdata.radius);
        mul_b   = MulW'(widen_q);
        prod_en = 1'b1;
        d2_d    = d2_q + DistW'(prod_q[31:0]);
        state_d = StWSq;
      end
      StWSq: begin
        mul_a   = prod_q[MulW-1:0];
        mul_b   = prod_q[MulW-1:0];
        prod_en = 1'b1;
        state_d = StCmp;
      end
      StCmp: begin
        if (in_circle) begin
          cnt_re   = 1'b1;
          cnt_addr = idx_q;
          state_d  = StUpd;
        end else if (last_region) begin
          done_d  = 1'b1;
          state_d = StIdle;
        end else begin
          idx_d    = idx_q + RegionIdxW'(1);
          reg_re   = 1'b1;
          reg_addr = idx_q + RegionIdxW'(1);
          state_d  = StSqX;
        end
      end
      StUpd: begin
        cnt_we   = 1'b1;
        cnt_addr = idx_q;
        row_set  = 1'b1;
        done_d   = 1'b1;
        hit_d    = 1'b1;
        found_d  = idx_q;
        state_d  = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      done_q      <= 1'b0;
      row_valid_q <= '0;
      regions_q   <= RegionsReset;
      traits_q    <= TraitsReset;
      widen_q     <= WidenReset;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (clear_all) begin
        row_valid_q <= '0;
      end else if (row_set) begin
        row_valid_q[idx_q] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRegions: regions_q <= cfg_data_i[4:0];
          CfgTraits:  traits_q  <= cfg_data_i[3:0];
          CfgWiden:   widen_q   <= cfg_data_i[WidenW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    d2_q    <= d2_d;
    hit_q   <= hit_d;
    found_q <= found_d;
    count_q <= count_d;
    if (prod_en) begin
      prod_q <= prod_d;
    end
    if (accept) begin
      px_q      <= pos_x_i;
      py_q      <= pos_y_i;
      species_q <= species_id_i;
      entry_q   <= entry_i;
      tsel_q    <= trait_select_i;
    end
    if (mask_we) begin
      masks_q[entry_i[SpeciesW-1:0]] <= trait_mask_i;
    end
  end

  crtt_ram #(
    .Width(RegW),
    .Depth(MaxRegions)
  ) u_region_ram (
    .clk_i  (clk_i),
    .addr_i (reg_addr),
    .we_i   (reg_we),
    .wdata_i(reg_wdata),
    .re_i   (reg_re),
    .rdata_o(reg_rdata_raw)
  );

  crtt_ram #(
    .Width(RowW),
    .Depth(MaxRegions)
  ) u_count_ram (
    .clk_i  (clk_i),
    .addr_i (cnt_addr),
    .we_i   (cnt_we),
    .wdata_i(cnt_wdata),
    .re_i   (cnt_re),
    .rdata_o(cnt_rdata)
  );

  assign result_valid_o = done_q;
  assign hit_o          = hit_q;
  assign region_found_o = found_q;
  assign count_value_o  = count_q;

endmodule

[design/crtt_ram.sv]
module crtt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/crtt_checker.sv]
`include "circle_region_trait_tally_unit_defines.svh"

module crtt_checker
  import crtt_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  result_valid_o,
  input logic                  hit_o,
  input logic [RegionIdxW-1:0] region_found_o,
  input logic [CountOutW-1:0]  count_value_o
);

  `CRTT_ASSERT(a_no_result_while_busy, clk_i, rst_ni, busy |-> !result_valid_o)
  `CRTT_ASSERT(a_result_ends_busy, clk_i, rst_ni, $fell(busy) |-> result_valid_o)
  `CRTT_ASSERT_NEXT(a_item_answered, clk_i, rst_ni, start && !busy, result_valid_o || busy)
  `CRTT_ASSERT(a_miss_no_region, clk_i, rst_ni, (result_valid_o && !hit_o) |-> (region_found_o == '0))
  `CRTT_ASSERT(a_hit_no_count, clk_i, rst_ni, (result_valid_o && hit_o) |-> (count_value_o == '0))

endmodule

bind circle_region_trait_tally_unit crtt_checker u_crtt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .hit_o         (hit_o),
  .region_found_o(region_found_o),
  .count_value_o (count_value_o)
);
